// ===== src/ipc_pkg.sv =====
// shared constants and types for the inversion pair counter
package ipc_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 15;
    localparam int FILL_W    = $clog2(MAX_ITEMS + 1);
    localparam int HIT_W     = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
    localparam int SUM_W     = ((HIT_W > COUNT_W) ? HIT_W : COUNT_W) + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // token that walks down the chain of cells
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] key;
    } tok_t;

    // per-cell status seen by the controller
    typedef struct packed {
        logic hit;
        logic done;
    } cell_stat_t;

endpackage

// ===== src/inversion_pair_counter_unit.sv =====
// top level: streaming inversion pair counter built on a chain of compare cells
// an item that is stored is registered into the first cell and its token walks one cell per cycle
//   down to the first free cell, where it finishes and its result is registered; s_ready stays low
//   until that item has finished, so the chain holds one item at a time;
//   an item past capacity finishes on acceptance, without a walk along the chain
// reset: synchronous active-low aresetn clears fill count, total, overflow flag and all
//   handshake state; the stored values are left as they are and never read unwritten
module inversion_pair_counter_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          s_value,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ipc_pkg::COUNT_W-1:0] m_running_count,
    output logic                        m_last_out,
    output logic                        m_overflow
);

    localparam int N = ipc_pkg::MAX_ITEMS;

    // sequence state
    logic [ipc_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [ipc_pkg::COUNT_W-1:0] total_reg, total_next;
    logic                        ovf_reg, ovf_next;

    // item in flight
    logic                        busy_reg, busy_next;
    logic                        last_reg;
    logic [ipc_pkg::HIT_W-1:0]   acc_reg, acc_next;

    // result register plus one pending slot so a finished result can wait
    logic                        m_valid_reg, m_valid_next;
    logic [ipc_pkg::COUNT_W-1:0] m_count_reg, m_count_next;
    logic                        m_last_reg, m_last_next;
    logic                        m_ovf_reg, m_ovf_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [ipc_pkg::COUNT_W-1:0] pend_count_reg;
    logic                        pend_last_reg;
    logic                        pend_ovf_reg;

    // chain wiring
    ipc_pkg::tok_t       chain [0:N];
    ipc_pkg::cell_stat_t stat  [0:N-1];
    logic [N-1:0]        tail;
    logic [N-1:0]        hit_vec;
    logic [N-1:0]        done_vec;

    logic                       accept;
    logic                       room;
    logic                       inject;
    logic                       any_hit;
    logic                       any_done;
    logic                       fin_event;
    logic                       fin_last;
    logic                       fin_ovf;
    logic [ipc_pkg::COUNT_W-1:0] fin_count;
    logic [ipc_pkg::SUM_W-1:0]   sum;
    logic                       out_free;

    assign s_ready = !busy_reg && !pend_valid_reg;
    assign accept  = s_valid && s_ready;
    assign room    = fill_reg < ipc_pkg::FILL_W'(N);
    assign inject  = accept && room;

    // token enters the first cell as an order-preserving unsigned key
    assign chain[0].valid = inject;
    assign chain[0].key   = {~s_value[31], s_value[30:0]};

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            // first free cell is the end of the walk
            assign tail[gi]     = (fill_reg == ipc_pkg::FILL_W'(gi));
            assign hit_vec[gi]  = stat[gi].hit;
            assign done_vec[gi] = stat[gi].done;

            ipc_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tok_in  (chain[gi]),
                .tail    (tail[gi]),
                .tok_out (chain[gi+1]),
                .stat    (stat[gi])
            );
        end
    endgenerate

    // only one token is in the chain, so at most one cell hits per cycle
    assign any_hit  = |hit_vec;
    assign any_done = |done_vec;

    always_comb begin
        acc_next = acc_reg;
        if (inject) begin
            acc_next = '0;
        end else if (any_hit) begin
            acc_next = acc_reg + ipc_pkg::HIT_W'(1);
        end
    end

    // finishing: either the token reached the free cell or the item found no room
    assign sum       = ipc_pkg::SUM_W'(total_reg) + ipc_pkg::SUM_W'(acc_reg);
    assign fin_event = any_done || (accept && !room);

    always_comb begin
        if (any_done) begin
            fin_last  = last_reg;
            fin_ovf   = ovf_reg;
            fin_count = (sum > ipc_pkg::SUM_W'(ipc_pkg::COUNT_MAX))
                        ? ipc_pkg::COUNT_MAX : sum[ipc_pkg::COUNT_W-1:0];
        end else begin
            fin_last  = s_last;
            fin_ovf   = 1'b1;
            fin_count = total_reg;
        end
    end

    // sequence state update, cleared when the closing transaction finishes
    always_comb begin
        fill_next  = fill_reg;
        total_next = total_reg;
        ovf_next   = ovf_reg;
        busy_next  = busy_reg;
        if (inject) begin
            busy_next = 1'b1;
        end else if (any_done) begin
            busy_next = 1'b0;
        end
        if (fin_event) begin
            if (fin_last) begin
                fill_next  = '0;
                total_next = '0;
                ovf_next   = 1'b0;
            end else begin
                total_next = fin_count;
                ovf_next   = fin_ovf;
                if (any_done) begin
                    fill_next = fill_reg + ipc_pkg::FILL_W'(1);
                end
            end
        end
    end

    // output side: result register fed from the pending slot or directly
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_count_next    = m_count_reg;
        m_last_next     = m_last_reg;
        m_ovf_next      = m_ovf_reg;
        pend_valid_next = pend_valid_reg;
        if (pend_valid_reg && out_free) begin
            m_valid_next    = 1'b1;
            m_count_next    = pend_count_reg;
            m_last_next     = pend_last_reg;
            m_ovf_next      = pend_ovf_reg;
            pend_valid_next = 1'b0;
        end else if (fin_event && out_free) begin
            m_valid_next = 1'b1;
            m_count_next = fin_count;
            m_last_next  = fin_last;
            m_ovf_next   = fin_ovf;
        end else if (fin_event) begin
            pend_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            total_reg      <= '0;
            ovf_reg        <= 1'b0;
            busy_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            fill_reg       <= fill_next;
            total_reg      <= total_next;
            ovf_reg        <= ovf_next;
            busy_reg       <= busy_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        m_count_reg <= m_count_next;
        m_last_reg  <= m_last_next;
        m_ovf_reg   <= m_ovf_next;
        if (accept) begin
            last_reg <= s_last;
        end
        if (fin_event && !out_free) begin
            pend_count_reg <= fin_count;
            pend_last_reg  <= fin_last;
            pend_ovf_reg   <= fin_ovf;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_running_count = m_count_reg;
    assign m_last_out      = m_last_reg;
    assign m_overflow      = m_ovf_reg;

endmodule

// ===== src/ipc_cell.sv =====
// one chain cell: holds a stored key and compares the passing token against it
module ipc_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  ipc_pkg::tok_t      tok_in,
    input  logic               tail,
    output ipc_pkg::tok_t      tok_out,
    output ipc_pkg::cell_stat_t stat
);

    logic                        tok_valid_reg;
    logic [ipc_pkg::VALUE_W-1:0] tok_key_reg;
    logic [ipc_pkg::VALUE_W-1:0] stored_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        tok_key_reg <= tok_in.key;
        // token ends its walk here: this cell takes the value
        if (tok_valid_reg && tail) begin
            stored_reg <= tok_key_reg;
        end
    end

    always_comb begin
        tok_out.valid = tok_valid_reg && !tail;
        tok_out.key   = tok_key_reg;
        stat.hit      = tok_valid_reg && !tail && (stored_reg > tok_key_reg);
        stat.done     = tok_valid_reg && tail;
    end

endmodule
